// ===== src/lpmr_pkg.sv =====
// Shared constants, types and helpers of the length-prefixed message ring.
package lpmr_pkg;

  localparam int RING_BYTES   = 4096;
  localparam int HEADER_BYTES = 2;

  localparam int PTR_W  = $clog2(RING_BYTES);
  localparam int FREE_W = $clog2(RING_BYTES + 1);
  localparam int LEN_W  = 12;
  localparam int CNT_W  = 12;
  localparam int HDR_W  = 8 * HEADER_BYTES;
  localparam int HBUF_W = (HDR_W > LEN_W) ? HDR_W : LEN_W;
  localparam int HCNT_W = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
  localparam int NEED_W = ((LEN_W > FREE_W) ? LEN_W : FREE_W) + 1;
  localparam bit HDR_LIMITED = (HDR_W < LEN_W);

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_ROOM = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_ORDER   = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [LEN_W-1:0] msg_length;
    logic [7:0]       data_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  read_byte;
    logic        last_of_message;
    logic [12:0] free_bytes;
    logic [11:0] message_count;
  } res_t;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [7:0]       wdata;
    logic [PTR_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(RING_BYTES - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

// ===== src/lpmr_req_if.sv =====
// Request channel: one operation per handshake.
interface lpmr_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [11:0] msg_length;
  logic [7:0] data_byte;

  modport source (output valid, op, msg_length, data_byte, input ready);
  modport sink   (input valid, op, msg_length, data_byte, output ready);
endinterface

// ===== src/lpmr_rsp_if.sv =====
// Result channel: one result per request.
interface lpmr_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  read_byte;
  logic        last_of_message;
  logic [12:0] free_bytes;
  logic [11:0] message_count;

  modport source (output valid, status, read_byte, last_of_message, free_bytes,
                  message_count, input ready);
  modport sink   (input valid, status, read_byte, last_of_message, free_bytes,
                  message_count, output ready);
endinterface

// ===== src/length_prefixed_message_ring_core.sv =====
// Top level: length-prefixed message ring with ring RAM, sequencer and result register.
//
//   channel  dir  payload                                               handshake
//   req      in   op, msg_length, data_byte                             valid/ready
//   rsp      out  status, read_byte, last_of_message, free_bytes,       valid/ready
//                 message_count
//
// One request at a time. A write stores its byte and is done; a start writes the first
// header byte, then the rest in S_WR_HDR. A read that opens a message takes the header
// in S_RD_HDR, then a body byte in S_RD_BODY (none for a header-only message); a body
// read goes to S_RD_BODY. One registered ring RAM read port: one byte per cycle.
// Synchronous reset clears pointers and counts at once; the ring RAM is not cleared.
// A finished result waits in the output register while the next request is taken.
module length_prefixed_message_ring_core (
  input  logic      clk,
  input  logic      rst,
  lpmr_req_if.sink  req,
  lpmr_rsp_if.source rsp
);

  lpmr_pkg::item_t    item;
  lpmr_pkg::mem_req_t mem;
  lpmr_pkg::res_t     res;
  logic [7:0]         rdata;
  logic               idle;
  logic               res_valid;
  logic               res_take;
  logic               ovalid;
  lpmr_pkg::res_t     ores;

  assign item.op         = req.op;
  assign item.msg_length = req.msg_length;
  assign item.data_byte  = req.data_byte;
  assign req.ready       = idle;

  lpmr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (req.valid),
    .item       (item),
    .idle       (idle),
    .mem        (mem),
    .rdata      (rdata),
    .res_valid  (res_valid),
    .res        (res),
    .res_take   (res_take)
  );

  lpmr_ram #(
    .WIDTH (8),
    .DEPTH (lpmr_pkg::RING_BYTES)
  ) u_ring (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .raddr (mem.raddr),
    .rdata (rdata)
  );

  assign res_take = res_valid && (!ovalid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (res_take) begin
      ovalid <= 1'b1;
    end else if (rsp.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      ores <= res;
    end
  end

  assign rsp.valid           = ovalid;
  assign rsp.status          = ores.status;
  assign rsp.read_byte       = ores.read_byte;
  assign rsp.last_of_message = ores.last_of_message;
  assign rsp.free_bytes      = ores.free_bytes;
  assign rsp.message_count   = ores.message_count;

  a_accept_only_idle: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |-> !res_valid)
    else $error("request taken while a result is pending");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.free_bytes <= 13'(lpmr_pkg::RING_BYTES))
    else $error("free count above ring size");

  a_error_no_byte: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != lpmr_pkg::ST_OK |-> res.read_byte == 8'd0 &&
      !res.last_of_message)
    else $error("byte returned with error status");

  a_take_loads: assert property (@(posedge clk) disable iff (rst)
    res_take |=> ovalid)
    else $error("result lost at output register");

endmodule

// ===== src/lpmr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lpmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/lpmr_ctrl.sv =====
// Sequencer: pointers, counts and the ring RAM access order for each request.
module lpmr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  lpmr_pkg::item_t     item,
  output logic                idle,
  output lpmr_pkg::mem_req_t  mem,
  input  logic [7:0]          rdata,
  output logic                res_valid,
  output lpmr_pkg::res_t      res,
  input  logic                res_take
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_WR_HDR  = 5'b00010,
    S_RD_HDR  = 5'b00100,
    S_RD_BODY = 5'b01000,
    S_DONE    = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [lpmr_pkg::PTR_W-1:0]  wp, wp_next, rp, rp_next;
  logic [lpmr_pkg::FREE_W-1:0] free_cnt, free_cnt_next;
  logic [lpmr_pkg::CNT_W-1:0]  msgs, msgs_next;
  logic [lpmr_pkg::LEN_W-1:0]  wleft, wleft_next, rleft, rleft_next;
  logic                        wopen, wopen_next, ropen, ropen_next;
  logic [lpmr_pkg::HCNT_W-1:0] hcnt, hcnt_next;
  logic [lpmr_pkg::HBUF_W-1:0] hdr, hdr_next, hdr_now;
  logic [1:0]                  status, status_next;
  logic [7:0]                  rbyte, rbyte_next;
  logic                        last, last_next;
  logic [lpmr_pkg::NEED_W-1:0] need;
  logic                        too_long;

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  assign res.status          = status;
  assign res.read_byte       = rbyte;
  assign res.last_of_message = last;
  assign res.free_bytes      = 13'(free_cnt);
  assign res.message_count   = 12'(msgs);

  assign need = lpmr_pkg::NEED_W'(item.msg_length) +
                lpmr_pkg::NEED_W'(lpmr_pkg::HEADER_BYTES);
  assign too_long = lpmr_pkg::HDR_LIMITED &&
                    ((lpmr_pkg::HBUF_W'(item.msg_length) >> lpmr_pkg::HDR_W) != '0);

  always_comb begin
    hdr_now = hdr;
    hdr_now[hcnt*8 +: 8] = rdata;
  end

  always_comb begin
    state_next    = state;
    wp_next       = wp;
    rp_next       = rp;
    free_cnt_next = free_cnt;
    msgs_next     = msgs;
    wleft_next    = wleft;
    rleft_next    = rleft;
    wopen_next    = wopen;
    ropen_next    = ropen;
    hcnt_next     = hcnt;
    hdr_next      = hdr;
    status_next   = status;
    rbyte_next    = rbyte;
    last_next     = last;
    mem.we        = 1'b0;
    mem.waddr     = wp;
    mem.wdata     = hdr[hcnt*8 +: 8];
    mem.raddr     = rp;

    case (state)
      S_IDLE: begin
        if (item_valid) begin
          status_next = lpmr_pkg::ST_OK;
          rbyte_next  = '0;
          last_next   = 1'b0;
          state_next  = S_DONE;
          case (item.op)
            lpmr_pkg::OP_START: begin
              if (wopen) begin
                status_next = lpmr_pkg::ST_ORDER;
              end else if (too_long || need > lpmr_pkg::NEED_W'(free_cnt)) begin
                status_next = lpmr_pkg::ST_NO_ROOM;
              end else begin
                free_cnt_next = free_cnt - lpmr_pkg::FREE_W'(need);
                hdr_next      = lpmr_pkg::HBUF_W'(item.msg_length);
                mem.we        = 1'b1;
                mem.wdata     = item.msg_length[7:0];
                wp_next       = lpmr_pkg::ptr_inc(wp);
                if (lpmr_pkg::HEADER_BYTES > 1) begin
                  hcnt_next  = lpmr_pkg::HCNT_W'(1);
                  state_next = S_WR_HDR;
                end
                if (item.msg_length == '0) begin
                  msgs_next = msgs + 1'b1;
                end else begin
                  wleft_next = item.msg_length;
                  wopen_next = 1'b1;
                end
              end
            end
            lpmr_pkg::OP_WRITE: begin
              if (!wopen) begin
                status_next = lpmr_pkg::ST_ORDER;
              end else begin
                mem.we     = 1'b1;
                mem.wdata  = item.data_byte;
                wp_next    = lpmr_pkg::ptr_inc(wp);
                wleft_next = wleft - 1'b1;
                if (wleft == lpmr_pkg::LEN_W'(1)) begin
                  wopen_next = 1'b0;
                  msgs_next  = msgs + 1'b1;
                end
              end
            end
            lpmr_pkg::OP_READ: begin
              if (!ropen && msgs == '0) begin
                status_next = lpmr_pkg::ST_EMPTY;
              end else begin
                // read of rp is issued now; data lands next cycle
                rp_next       = lpmr_pkg::ptr_inc(rp);
                free_cnt_next = free_cnt + 1'b1;
                if (ropen) begin
                  state_next = S_RD_BODY;
                end else begin
                  hcnt_next  = '0;
                  hdr_next   = '0;
                  state_next = S_RD_HDR;
                end
              end
            end
            default: begin
              status_next = lpmr_pkg::ST_ORDER;
            end
          endcase
        end
      end
      S_WR_HDR: begin
        mem.we  = 1'b1;
        wp_next = lpmr_pkg::ptr_inc(wp);
        if (hcnt == lpmr_pkg::HCNT_W'(lpmr_pkg::HEADER_BYTES - 1)) begin
          state_next = S_DONE;
        end else begin
          hcnt_next = hcnt + 1'b1;
        end
      end
      S_RD_HDR: begin
        hdr_next = hdr_now;
        if (hcnt != lpmr_pkg::HCNT_W'(lpmr_pkg::HEADER_BYTES - 1)) begin
          rp_next       = lpmr_pkg::ptr_inc(rp);
          free_cnt_next = free_cnt + 1'b1;
          hcnt_next     = hcnt + 1'b1;
        end else if (hdr_now[lpmr_pkg::LEN_W-1:0] == '0) begin
          // header-only message: done without a body read
          last_next  = 1'b1;
          ropen_next = 1'b0;
          if (msgs != '0) begin
            msgs_next = msgs - 1'b1;
          end
          state_next = S_DONE;
        end else begin
          ropen_next    = 1'b1;
          rleft_next    = hdr_now[lpmr_pkg::LEN_W-1:0];
          rp_next       = lpmr_pkg::ptr_inc(rp);
          free_cnt_next = free_cnt + 1'b1;
          state_next    = S_RD_BODY;
        end
      end
      S_RD_BODY: begin
        rbyte_next = rdata;
        rleft_next = rleft - 1'b1;
        if (rleft == lpmr_pkg::LEN_W'(1)) begin
          last_next  = 1'b1;
          ropen_next = 1'b0;
          if (msgs != '0) begin
            msgs_next = msgs - 1'b1;
          end
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      wp       <= '0;
      rp       <= '0;
      free_cnt <= lpmr_pkg::FREE_W'(lpmr_pkg::RING_BYTES);
      msgs     <= '0;
      wleft    <= '0;
      rleft    <= '0;
      wopen    <= 1'b0;
      ropen    <= 1'b0;
      hcnt     <= '0;
    end else begin
      state    <= state_next;
      wp       <= wp_next;
      rp       <= rp_next;
      free_cnt <= free_cnt_next;
      msgs     <= msgs_next;
      wleft    <= wleft_next;
      rleft    <= rleft_next;
      wopen    <= wopen_next;
      ropen    <= ropen_next;
      hcnt     <= hcnt_next;
    end
  end

  always_ff @(posedge clk) begin
    hdr    <= hdr_next;
    status <= status_next;
    rbyte  <= rbyte_next;
    last   <= last_next;
  end

endmodule
